FILE: src/ptlu_pkg.sv
package ptlu_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_INPUT_BYTES       = 2'd0;
   localparam logic [1:0] CSR_BIG_ENDIAN_SOURCE = 2'd1;
   localparam logic [1:0] CSR_RATE_MODE         = 2'd2;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 4;

   localparam int unsigned RAW_W    = 64;
   localparam int unsigned RAW_BYTES = RAW_W / 8;
   localparam int unsigned SAMPLE_W = 16;

   localparam logic [3:0] INPUT_BYTES_RESET = 4'd2;

   // unsigned 8-bit expansion: (b - 128) * 255
   localparam logic signed [9:0]  U8_BIAS  = 10'sd128;
   localparam logic signed [17:0] U8_SCALE = 18'sd255;

   typedef enum logic [1:0] {
      RATE_X1 = 2'd0,
      RATE_X2 = 2'd1,
      RATE_X4 = 2'd2
   } rate_mode_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

FILE: src/pcm_to16_linear_upsampler.sv
// PCM sample converter and linear upsampler. Each request transaction carries one raw
// mono sample of 1 to 8 bytes (first memory byte in the low bits) and a block-start
// flag in tuser; it is turned into signed 16 bits and leaves as 1, 2 or 4 response
// transactions (x1, x2, x4) interpolated between the previous and the current sample,
// the last one of each item marked by tlast. One response is produced per cycle through
// the output register while rsp_tready does not stall it; the next request is taken in
// the same cycle as the final response of the current one leaves the work register.
// The configuration port may only be written while no item is in flight.
module pcm_to16_linear_upsampler
   import ptlu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [RAW_W-1:0]      req_tdata,   // [63:0] raw_sample
   input  logic                  req_tuser,   // [0] block_start

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,   // [15:0] sample_out
   output logic                  rsp_tlast    // last_of_run
);

   // configuration
   logic [3:0]    input_bytes_ff;
   logic          big_endian_ff;
   rate_mode_type rate_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_bytes_ff <= INPUT_BYTES_RESET;
         big_endian_ff  <= 1'b0;
         rate_mode_ff   <= RATE_X1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_INPUT_BYTES:       input_bytes_ff <= csr_wdata;
            CSR_BIG_ENDIAN_SOURCE: big_endian_ff  <= csr_wdata[0];
            CSR_RATE_MODE:         rate_mode_ff   <= rate_mode_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   // format conversion
   logic [7:0]        raw_byte [RAW_BYTES];
   logic [3:0]        nbytes;
   logic [3:0]        idx_hi_w;
   logic [3:0]        idx_lo_w;
   logic signed [9:0] u8_delta;
   logic signed [17:0] u8_scaled;
   sample_type        conv_sample;

   always_comb begin
      for (int i = 0; i < RAW_BYTES; i++) begin
         raw_byte[i] = req_tdata[i*8 +: 8];
      end
      if (input_bytes_ff == 4'd0) begin
         nbytes = 4'd1;
      end else if (input_bytes_ff > 4'd8) begin
         nbytes = 4'd8;
      end else begin
         nbytes = input_bytes_ff;
      end
      idx_hi_w  = nbytes - 4'd1;
      idx_lo_w  = nbytes - 4'd2;
      u8_delta  = $signed({2'b00, raw_byte[0]}) - U8_BIAS;
      u8_scaled = 18'(u8_delta) * U8_SCALE;
      if (nbytes == 4'd1) begin
         conv_sample = u8_scaled[15:0];
      end else if (big_endian_ff) begin
         conv_sample = {raw_byte[0], raw_byte[1]};
      end else begin
         conv_sample = {raw_byte[idx_hi_w[2:0]], raw_byte[idx_lo_w[2:0]]};
      end
   end

   // work register: holds one item while its responses are produced
   logic          work_valid_ff, work_valid_in;
   logic [1:0]    work_phase_ff, work_phase_in;
   rate_mode_type work_mode_ff;
   sample_type    work_p_ff, work_s_ff;
   sample_type    prev_ff;

   logic          rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic out_load;
   logic emit;
   logic req_accept;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign emit       = work_valid_ff && out_load;
   assign req_tready = !work_valid_ff || (out_load && rsp_last_in);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      work_valid_in = work_valid_ff;
      work_phase_in = work_phase_ff;
      if (req_accept) begin
         work_valid_in = 1'b1;
         work_phase_in = 2'd0;
      end else if (emit && rsp_last_in) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         work_phase_in = work_phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         work_phase_ff <= 2'd0;
         prev_ff       <= '0;
      end else begin
         work_valid_ff <= work_valid_in;
         work_phase_ff <= work_phase_in;
         if (req_accept) begin
            prev_ff <= conv_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         work_mode_ff <= rate_mode_ff;
         work_p_ff    <= req_tuser ? '0 : prev_ff;
         work_s_ff    <= conv_sample;
      end
   end

   // interpolation, averages truncate toward zero
   logic signed [16:0] sum_ps;
   logic signed [17:0] sum_3ps, sum_p3s;
   logic signed [16:0] half_ps;
   logic signed [17:0] qtr_3ps, qtr_p3s;

   always_comb begin
      sum_ps  = 17'(work_p_ff) + 17'(work_s_ff);
      sum_3ps = 18'(work_p_ff) + 18'(work_p_ff) + 18'(work_p_ff) + 18'(work_s_ff);
      sum_p3s = 18'(work_p_ff) + 18'(work_s_ff) + 18'(work_s_ff) + 18'(work_s_ff);
      half_ps = (sum_ps + 17'(sum_ps[16])) >>> 1;
      qtr_3ps = (sum_3ps + (sum_3ps[17] ? 18'sd3 : 18'sd0)) >>> 2;
      qtr_p3s = (sum_p3s + (sum_p3s[17] ? 18'sd3 : 18'sd0)) >>> 2;

      case (work_mode_ff)
         RATE_X1: begin
            rsp_data_in = work_s_ff;
            rsp_last_in = 1'b1;
         end
         RATE_X2: begin
            rsp_data_in = (work_phase_ff == 2'd0) ? work_p_ff : half_ps[15:0];
            rsp_last_in = (work_phase_ff == 2'd1);
         end
         default: begin
            case (work_phase_ff)
               2'd0:    rsp_data_in = work_p_ff;
               2'd1:    rsp_data_in = qtr_3ps[15:0];
               2'd2:    rsp_data_in = half_ps[15:0];
               default: rsp_data_in = qtr_p3s[15:0];
            endcase
            rsp_last_in = (work_phase_ff == 2'd3);
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= work_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: src/ptlu_checker.sv
module ptlu_checker
   import ptlu_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [SAMPLE_W-1:0] rsp_tdata,
   input logic                rsp_tlast
);

   // items taken whose final response has not left yet
   logic [2:0] open_items_ff;
   logic       req_fire;
   logic       rsp_end;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_end  = rsp_tvalid && rsp_tready && rsp_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_items_ff <= '0;
      end else begin
         open_items_ff <= open_items_ff + 3'(req_fire) - 3'(rsp_end);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response payload changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> open_items_ff != 3'd0)
      else $error("response without an open request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      open_items_ff <= 3'd2)
      else $error("more items in flight than the pipeline holds");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind pcm_to16_linear_upsampler ptlu_checker u_ptlu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
